@@ rtl/acs_pkg.sv @@
// Shared constants for the accumulator CPU step core.
// Holds action selectors, addressing modes, operation codes and item widths.
// No dependencies.
package acs_pkg;

  localparam int DATA_W = 16;
  localparam int PC_W   = 8;

  // Action selector carried in the input word's tuser.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_EXEC  = 2'd2;

  // Addressing modes in the two low opcode bits.
  localparam logic [1:0] MODE_ABS = 2'd0;
  localparam logic [1:0] MODE_LIT = 2'd1;
  localparam logic [1:0] MODE_IDX = 2'd2;
  localparam logic [1:0] MODE_REL = 2'd3;

  localparam int DIR_BIT = 2;

  // Operation codes in opcode bits 15..4.
  localparam logic [11:0] OP_MOVE = 12'd0;
  localparam logic [11:0] OP_ADD  = 12'd1;
  localparam logic [11:0] OP_SUB  = 12'd2;
  localparam logic [11:0] OP_BRA  = 12'd3;
  localparam logic [11:0] OP_CMP  = 12'd4;
  localparam logic [11:0] OP_BEQ  = 12'd5;
  localparam logic [11:0] OP_BNE  = 12'd6;
  localparam logic [11:0] OP_EXG  = 12'd7;
  localparam logic [11:0] OP_STOP = 12'd15;

endpackage

@@ rtl/acs_addr_wrap.sv @@
// Address reduction unit: returns a 16-bit value modulo the memory depth.
// Uses acs_pkg for the data width.
// A power-of-two depth is a mask; any other depth uses a reciprocal multiply, a subtract and a correction.
module acs_addr_wrap
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = 256,
  parameter int AW        = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req,
  input  logic [DATA_W-1:0] value,
  output logic              done,
  output logic [AW-1:0]     result
);

  localparam bit IS_POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;

  typedef enum logic [1:0] {
    P_IDLE, P_MUL, P_SUB, P_FIX
  } phase_t;

  generate
    if (IS_POW2) begin : g_mask
      assign done   = req;
      assign result = value[AW-1:0];
    end else begin : g_recip
      // floor(2^32 / depth) makes the quotient estimate low by at most one, so one
      // compare and subtract finishes the remainder.
      localparam logic [31:0]     RECIP   = 32'((64'd1 << 32) / MEM_DEPTH);
      localparam logic [DATA_W:0] DEPTH_W = (DATA_W + 1)'(MEM_DEPTH);

      phase_t              phase;
      logic                fin;
      logic [DATA_W-1:0]   x;
      logic [DATA_W+31:0]  prod;
      logic [DATA_W-1:0]   quot;
      logic [31:0]         qd;
      logic [DATA_W-1:0]   rem_raw;
      logic [DATA_W-1:0]   rem;
      logic [DATA_W:0]     rem_fix;

      assign quot    = prod[DATA_W+31:32];
      assign qd      = {{(32 - DATA_W){1'b0}}, quot} * 32'(MEM_DEPTH);
      assign rem_fix = ({1'b0, rem_raw} >= DEPTH_W) ? ({1'b0, rem_raw} - DEPTH_W)
                                                    : {1'b0, rem_raw};

      always_ff @(posedge clk) begin
        if (rst) begin
          phase <= P_IDLE;
          fin   <= 1'b0;
        end else begin
          fin <= (phase == P_FIX);
          unique case (phase)
            P_IDLE: begin
              if (req && !fin) begin
                x     <= value;
                phase <= P_MUL;
              end
            end
            P_MUL: begin
              prod  <= {{32{1'b0}}, x} * {{DATA_W{1'b0}}, RECIP};
              phase <= P_SUB;
            end
            P_SUB: begin
              rem_raw <= x - qd[DATA_W-1:0];
              phase   <= P_FIX;
            end
            default: begin
              rem   <= rem_fix[DATA_W-1:0];
              phase <= P_IDLE;
            end
          endcase
        end
      end

      assign done   = fin;
      assign result = rem[AW-1:0];
    end
  endgenerate

endmodule

@@ rtl/acs_word_mem.sv @@
// Single-port word memory with a registered read, read-before-write.
// Uses acs_pkg for the word width.
module acs_word_mem
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = 256,
  parameter int AW        = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [AW-1:0]     addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/accumulator_cpu_step_core.sv @@
// Accumulator CPU step core: a 16-bit machine with D0, A0, a zero flag, a PC and a
// word memory. Each input word writes a memory word, reads one, or runs one
// two-word instruction unless halted; each input word gives exactly one output word.
// Input channel s_axis: tuser selects the action, tdata carries address and data.
// Output channel m_axis: the read word and the machine state after the action.
// From acceptance: a write passes S_WIO, a read S_WIO and S_RD, an instruction S_WPC0,
// S_OPC, S_WPC1, S_ARG, S_WEA, S_SRC and S_EXEC (a literal operand skips S_WEA and S_SRC);
// each then goes to S_DONE, and the input takes the next word in the cycle after the result
// is registered. The sequence is set by the single memory port: opcode fetch, operand fetch,
// source read and write-back each use it in turn. With a power-of-two MEM_DEPTH addresses are
// masked combinationally; any other depth makes every address reduction wait on acs_addr_wrap.
// The result sits in an output register; a new word can be accepted while it waits,
// but the next result is held back until the receiver takes the previous one.
// Reset clears PC, D0, A0, the zero flag and the halt latch; memory contents are
// undefined until written and need no clearing pass.
// Depends on acs_pkg, acs_addr_wrap and acs_word_mem.
module accumulator_cpu_step_core
  import acs_pkg::*;
#(
  parameter int MEM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // mem_addr[7:0], mem_data[23:8]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_word[15:0], prog_counter[23:16], data_reg[39:24], addr_reg[55:40],
  // zero_flag[56], halted[57], zero fill[63:58]
  output logic [63:0] m_axis_tdata
);

  localparam int AW = $clog2(MEM_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_WIO, S_RD, S_WPC0, S_OPC, S_WPC1, S_ARG, S_WEA, S_SRC, S_EXEC, S_DONE
  } state_t;

  state_t            state;
  logic [1:0]        func;
  logic [PC_W-1:0]   in_addr;
  logic [DATA_W-1:0] in_data;
  logic [PC_W-1:0]   pc_reg;
  logic [DATA_W-1:0] d_reg;
  logic [DATA_W-1:0] a_reg;
  logic              z_flag;
  logic              stop_flag;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] op_word;
  logic [DATA_W-1:0] arg_word;
  logic [DATA_W-1:0] src_word;
  logic [AW-1:0]     ea;

  logic              wrap_req;
  logic [DATA_W-1:0] wrap_value;
  logic              wrap_done;
  logic [AW-1:0]     wrap_result;
  logic              mem_en;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  logic [1:0]        mode;
  logic              dir;
  logic [11:0]       kind;
  logic [DATA_W-1:0] ea_value;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] diff;
  logic              do_store;
  logic [DATA_W-1:0] store_word;
  logic              take_branch;
  logic              s_fire;

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign mode = op_word[1:0];
  assign dir  = op_word[DIR_BIT];
  assign kind = op_word[15:4];
  assign sum  = d_reg + src_word;
  assign diff = d_reg - src_word;

  always_comb begin
    unique case (mode)
      MODE_IDX: ea_value = a_reg + arg_word;
      MODE_REL: ea_value = {{(DATA_W - PC_W){1'b0}}, pc_reg} + arg_word;
      default:  ea_value = arg_word;
    endcase
  end

  // Memory is written back only by MOVE, ADD and SUB toward memory with a real address.
  always_comb begin
    do_store   = 1'b0;
    store_word = d_reg;
    if (!dir && mode != MODE_LIT) begin
      unique case (kind)
        OP_MOVE: do_store = 1'b1;
        OP_ADD: begin
          do_store   = 1'b1;
          store_word = sum;
        end
        OP_SUB: begin
          do_store   = 1'b1;
          store_word = diff;
        end
        default: do_store = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (kind)
      OP_BRA:  take_branch = 1'b1;
      OP_BEQ:  take_branch = z_flag;
      OP_BNE:  take_branch = !z_flag;
      default: take_branch = 1'b0;
    endcase
  end

  always_comb begin
    wrap_req   = 1'b0;
    wrap_value = {{(DATA_W - PC_W){1'b0}}, pc_reg};
    unique case (state)
      S_WIO: begin
        wrap_req   = 1'b1;
        wrap_value = {{(DATA_W - PC_W){1'b0}}, in_addr};
      end
      S_WPC0, S_WPC1: wrap_req = 1'b1;
      S_WEA: begin
        wrap_req   = 1'b1;
        wrap_value = ea_value;
      end
      default: wrap_req = 1'b0;
    endcase
  end

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = wrap_result;
    mem_wdata = in_data;
    unique case (state)
      S_WIO: begin
        mem_en = wrap_done;
        mem_we = wrap_done && (func == FUNC_WRITE);
      end
      S_WPC0, S_WPC1, S_WEA: mem_en = wrap_done;
      S_EXEC: begin
        mem_en    = do_store;
        mem_we    = do_store;
        mem_addr  = ea;
        mem_wdata = store_word;
      end
      default: mem_en = 1'b0;
    endcase
  end

  acs_addr_wrap #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_wrap (
    .clk    (clk),
    .rst    (rst),
    .req    (wrap_req),
    .value  (wrap_value),
    .done   (wrap_done),
    .result (wrap_result)
  );

  acs_word_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pc_reg        <= '0;
      d_reg         <= '0;
      a_reg         <= '0;
      z_flag        <= 1'b0;
      stop_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            func    <= s_axis_tuser;
            in_addr <= s_axis_tdata[7:0];
            in_data <= s_axis_tdata[23:8];
            rd_word <= '0;
            if (s_axis_tuser == FUNC_WRITE || s_axis_tuser == FUNC_READ) begin
              state <= S_WIO;
            end else if (s_axis_tuser == FUNC_EXEC && !stop_flag) begin
              state <= S_WPC0;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WIO: begin
          if (wrap_done) state <= (func == FUNC_READ) ? S_RD : S_DONE;
        end
        S_RD: begin
          rd_word <= mem_rdata;
          state   <= S_DONE;
        end
        S_WPC0: begin
          if (wrap_done) begin
            pc_reg <= pc_reg + 1'b1;
            state  <= S_OPC;
          end
        end
        S_OPC: begin
          op_word <= mem_rdata;
          state   <= S_WPC1;
        end
        S_WPC1: begin
          if (wrap_done) begin
            pc_reg <= pc_reg + 1'b1;
            state  <= S_ARG;
          end
        end
        S_ARG: begin
          arg_word <= mem_rdata;
          src_word <= mem_rdata;
          state    <= (mode == MODE_LIT) ? S_EXEC : S_WEA;
        end
        S_WEA: begin
          if (wrap_done) begin
            ea    <= wrap_result;
            state <= S_SRC;
          end
        end
        S_SRC: begin
          src_word <= mem_rdata;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          unique case (kind)
            OP_MOVE: begin
              if (dir) begin
                d_reg  <= src_word;
                z_flag <= (src_word == '0);
              end else begin
                z_flag <= (d_reg == '0);
              end
            end
            OP_ADD: begin
              if (dir) d_reg <= sum;
              z_flag <= (sum == '0);
            end
            OP_SUB: begin
              if (dir) d_reg <= diff;
              z_flag <= (diff == '0);
            end
            OP_CMP: z_flag <= (diff == '0);
            OP_BRA, OP_BEQ, OP_BNE: begin
              if (take_branch && mode == MODE_ABS) begin
                pc_reg <= arg_word[PC_W-1:0];
              end else if (take_branch && mode == MODE_LIT) begin
                pc_reg <= pc_reg + arg_word[PC_W-1:0];
              end
            end
            OP_EXG: begin
              d_reg <= a_reg;
              a_reg <= d_reg;
            end
            OP_STOP: stop_flag <= 1'b1;
            default: ;
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {6'b0, stop_flag, z_flag, a_reg, d_reg, pc_reg, rd_word};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    stop_flag |=> stop_flag)
    else $error("halt latch cleared without reset");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_WIO || state == S_EXEC))
    else $error("memory written outside a write action or write-back");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_axis_tvalid && !m_axis_tready) |=> (state == S_DONE))
    else $error("result left the sequencer while the output word was stalled");

  a_pc_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(pc_reg))
    else $error("program counter moved while idle");
`endif

endmodule
